// ----- sv/lrf_pkg.sv -----
package lrf_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;
    localparam int ORDER_W = 6;
    localparam int SHIFT_W = 5;
    localparam int INDEX_W = 6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic REG_ORDER = 1'b0;
    localparam logic REG_SHIFT = 1'b1;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd20;

    typedef struct packed {
        logic                      operation;
        logic                      frame_start;
        logic signed [DATA_W-1:0]  sample;
        logic        [INDEX_W-1:0] coef_index;
        logic signed [DATA_W-1:0]  coef_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] residue;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- sv/lrf_ifs.sv -----
interface lrf_in_if import lrf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lrf_out_if import lrf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/lpc_residue_filter_top.sv -----
// Channel   Dir  Word fields                                           Handshake
// i_in      in   operation, frame_start, sample, coef_index, coef_value  valid/ready
// o_out     out  residue                                               valid/ready
// APB       in   order (addr 0), shift (addr 4)                        psel/penable
//
// A load word writes its coefficient and leaves the block ready for the next
// word. A sample word walks its taps, where taps is min(order, MAX_TAPS,
// samples already seen in the frame): one shared 32x32 multiplier and one
// 64-bit accumulator walk the taps, one per cycle, behind the registered
// coefficient and history memory reads, then drain two pipe stages.
// Reset (synchronous, active low) empties the history and sets order 1, shift 20.
// A finished residue waits in the output register; the next word is taken
// meanwhile, and only the following residue stalls until o_out is drained.
module lpc_residue_filter_top import lrf_pkg::*; #(
    parameter int MAX_TAPS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrf_in_if.sink             i_in,
    lrf_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [ORDER_W-1:0] r_order;
    logic [SHIFT_W-1:0] r_shift;
    logic               cfg_wr;
    t_dp_cmd            cmd;
    t_dp_stat           stat;

    // APB: zero wait states, decode the word address bit only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_shift <= SHIFT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ORDER) begin
                r_order <= pwdata[ORDER_W-1:0];
            end else begin
                r_shift <= pwdata[SHIFT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ORDER) begin
            prdata = {{(DATA_W - ORDER_W){1'b0}}, r_order};
        end else begin
            prdata = {{(DATA_W - SHIFT_W){1'b0}}, r_shift};
        end
    end

    // sequencer: accept, walk the taps, drain the MAC pipe, hand off residue
    lrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.payload.operation),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // memories, multiply-accumulate, rounding shift and output register
    lrf_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in.payload),
        .i_order     (r_order),
        .i_shift     (r_shift),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_residue   (o_out.payload.residue)
    );

endmodule

// ----- sv/lrf_ctrl.sv -----
module lrf_ctrl import lrf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_op,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = !i_stat.issue_done;
                if (i_stat.issue_done && !i_stat.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the residue
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/lrf_datapath.sv -----
module lrf_datapath import lrf_pkg::*; #(
    parameter int MAX_TAPS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_in_word                 i_word,
    input  logic [ORDER_W-1:0]       i_order,
    input  logic [SHIFT_W-1:0]       i_shift,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_residue
);

    localparam int HW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int DEPTH = 1 << HW;
    localparam int KW    = $clog2(MAX_TAPS + 1);

    // circular sample history and coefficient store (tap n at address n-1)
    logic [DATA_W-1:0] hist_mem [DEPTH];
    logic [DATA_W-1:0] coef_mem [DEPTH];

    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_coef_rd;
    logic signed [DATA_W-1:0] r_hist_rd;
    logic signed [ACC_W-1:0]  r_prod;
    logic        [ACC_W-1:0]  r_acc;
    logic        [KW-1:0]     r_fill;
    logic        [KW-1:0]     r_taps;
    logic        [KW-1:0]     r_k;
    logic        [HW-1:0]     r_wptr;
    logic                     r_rd_v;
    logic                     r_prod_v;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_residue;

    logic [KW-1:0]           fill_eff;
    logic [KW-1:0]           order_sat;
    logic [KW-1:0]           taps;
    logic [ACC_W-1:0]        acc_init;
    logic                    idx_ok;
    logic [INDEX_W-1:0]      idx_m1;
    logic [HW-1:0]           hist_addr;
    logic signed [ACC_W-1:0] pred;
    logic [DATA_W-1:0]       residue;

    always_comb begin
        fill_eff = i_word.frame_start ? '0 : r_fill;
        if ({1'b0, i_order} > (ORDER_W + 1)'(MAX_TAPS)) begin
            order_sat = KW'(MAX_TAPS);
        end else begin
            order_sat = KW'(i_order);
        end
        taps = (order_sat < fill_eff) ? order_sat : fill_eff;
        if (i_shift == '0) begin
            acc_init = '0;
        end else begin
            acc_init = ACC_W'(1) << (i_shift - SHIFT_W'(1));
        end
        idx_ok    = (i_word.coef_index != '0) &&
                    ({1'b0, i_word.coef_index} <= (INDEX_W + 1)'(MAX_TAPS));
        idx_m1    = i_word.coef_index - INDEX_W'(1);
        hist_addr = r_wptr - HW'(1) - r_k[HW-1:0];
        if (i_shift == '0) begin
            pred = $signed(r_acc);
        end else begin
            pred = $signed(r_acc) >>> i_shift;
        end
        residue = r_sample - pred[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && idx_ok) begin
            coef_mem[idx_m1[HW-1:0]] <= i_word.coef_value;
        end
        if (i_cmd.finish) begin
            hist_mem[r_wptr] <= r_sample;
        end
        r_coef_rd <= coef_mem[r_k[HW-1:0]];
        r_hist_rd <= hist_mem[hist_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_rd * r_hist_rd;
        if (i_cmd.start) begin
            r_sample <= i_word.sample;
            r_taps   <= taps;
            r_acc    <= acc_init;
        end else if (r_prod_v) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.finish) begin
            r_residue <= residue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_k         <= '0;
            r_wptr      <= '0;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
            if (i_cmd.start) begin
                r_k    <= '0;
                r_fill <= fill_eff;
            end else if (i_cmd.issue) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.finish) begin
                r_wptr      <= r_wptr + HW'(1);
                r_out_valid <= 1'b1;
                if (r_fill != KW'(MAX_TAPS)) begin
                    r_fill <= r_fill + KW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.issue_done = (r_k == r_taps);
    assign o_stat.pipe_busy  = r_rd_v | r_prod_v;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_residue         = r_residue;

endmodule

// ----- verif/lpc_residue_filter_top_test.sv -----
module lpc_residue_filter_top_test;
    import lrf_pkg::*;

    localparam int TAPS         = 32;
    localparam int HALF_PERIOD  = 10;
    localparam int SETTLE_CYC   = 50;     // covers the longest sample word, with TAPS taps
    localparam int HOLD_CYC     = 300;
    localparam int PHASE_WORDS  = 144;
    localparam int NUM_PHASES   = 8;
    localparam int SHOW_LIMIT   = 10;
    localparam int TIMEOUT_CYC  = 500000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lrf_in_if  in_ch ();
    lrf_out_if out_ch ();

    lpc_residue_filter_top #(.MAX_TAPS(TAPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Filter state mirrored on the bench side
    logic [ORDER_W-1:0]       cfg_order;
    logic [SHIFT_W-1:0]       cfg_shift;
    logic signed [DATA_W-1:0] hist_mem [TAPS];
    logic signed [DATA_W-1:0] coef_mem [1:TAPS];

    t_in_word          word_backlog [$];
    logic [DATA_W-1:0] residue_due  [$];

    logic word_taken;
    logic out_hold;
    logic hold_go;
    int   send_idle_pct;
    int   recv_stall_pct;

    int mismatches;
    int samples_run;
    int loads_run;
    int frames_run;
    int residues_seen;
    int settings_run;

    // Advance the filter by one accepted word; queue the residue it owes.
    task automatic filter_word(input t_in_word w);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] c64;
        logic signed [ACC_W-1:0] h64;
        logic [DATA_W-1:0]       pred;
        int                      taps;
        int                      i;
        if (w.operation == OP_LOAD) begin
            if (w.coef_index >= 1 && w.coef_index <= TAPS)
                coef_mem[w.coef_index] = w.coef_value;
            loads_run++;
            return;
        end
        if (w.frame_start) begin
            foreach (hist_mem[k]) hist_mem[k] = '0;
            frames_run++;
        end
        taps = (cfg_order > TAPS) ? TAPS : int'(cfg_order);
        acc  = (cfg_shift == 0) ? '0 : (64'sd1 <<< (cfg_shift - 1));
        for (i = 1; i <= taps; i++) begin
            c64 = coef_mem[i];
            h64 = hist_mem[i-1];
            acc = acc + c64 * h64;
        end
        acc  = acc >>> cfg_shift;
        pred = acc[DATA_W-1:0];
        residue_due.push_back(w.sample - pred);
        for (i = TAPS - 1; i > 0; i--)
            hist_mem[i] = hist_mem[i-1];
        hist_mem[0] = w.sample;
        samples_run++;
    endtask

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("MISMATCH %s: residue expected %h got %h", what, want, got);
    endtask

    // Check the output first, then predict from the input, so one edge has one order.
    always @(posedge i_clk) begin : watch
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                residues_seen++;
                if (residue_due.size() == 0) begin
                    flag_mismatch("with nothing due", 'x, out_ch.payload.residue);
                end else begin
                    want = residue_due.pop_front();
                    if (out_ch.payload.residue !== want)
                        flag_mismatch("on result", want, out_ch.payload.residue);
                end
            end
            if (in_ch.valid && in_ch.ready)
                filter_word(in_ch.payload);
            word_taken <= in_ch.valid && in_ch.ready;
        end
    end

    // Hold a word until taken, then offer the next one unless idling.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || word_taken) begin
            if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.payload <= word_backlog.pop_front();
                in_ch.valid   <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, so the output register fills and the input backs up.
    initial begin : pressure
        wait (hold_go);
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        out_hold = 1'b0;
    end

    initial begin : watchdog
        #(2 * HALF_PERIOD * TIMEOUT_CYC);
        $display("lpc_residue_filter_top regression: fail");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: return v;
            1: return $signed(v) >>> $urandom_range(8, 30);
            2: return v[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed(v) >>> 16;
        endcase
    endfunction

    function automatic t_in_word sample_word(input logic fs, input logic [DATA_W-1:0] s);
        t_in_word w;
        w.operation   = OP_SAMPLE;
        w.frame_start = fs;
        w.sample      = s;
        w.coef_index  = $urandom;
        w.coef_value  = $urandom;
        return w;
    endfunction

    function automatic t_in_word load_word(input logic [INDEX_W-1:0] idx,
                                           input logic [DATA_W-1:0] c);
        t_in_word w;
        w.operation   = OP_LOAD;
        w.frame_start = $urandom;
        w.sample      = $urandom;
        w.coef_index  = idx;
        w.coef_value  = c;
        return w;
    endfunction

    // Mostly samples in long frames, with coefficient updates sprinkled in;
    // a few loads aim at taps that do not exist.
    function automatic t_in_word make_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 2)
            return load_word($urandom_range(1) ? 6'd0 : INDEX_W'($urandom_range(33, 63)),
                             $urandom);
        if (pick < 9)
            return load_word(INDEX_W'($urandom_range(1, TAPS)), pick_value());
        return sample_word(pick >= 97, pick_value());
    endfunction

    task automatic write_reg(input logic which, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {which, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (which == REG_ORDER) cfg_order = value[ORDER_W-1:0];
        else                    cfg_shift = value[SHIFT_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain everything, then let a last load or sample word finish inside the block.
    task automatic settle();
        while (word_backlog.size() != 0 || in_ch.valid || residue_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [ORDER_W-1:0] order_plan [NUM_PHASES];
        logic [SHIFT_W-1:0] shift_plan [NUM_PHASES];
        int p;
        int n;
        order_plan = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd32, 6'd2, 6'd17, 6'd0};
        shift_plan = '{5'd31, 5'd1, 5'd0, 5'd31, 5'd20, 5'd1, 5'd15, 5'd0};

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        out_hold      = 1'b0;
        hold_go       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_order = ORDER_RESET;
        cfg_shift = SHIFT_RESET;
        foreach (hist_mem[k]) hist_mem[k] = '0;
        foreach (coef_mem[k]) coef_mem[k] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every tap first so no sample ever reads an unwritten coefficient.
        for (n = 1; n <= TAPS; n++)
            word_backlog.push_back(load_word(INDEX_W'(n), pick_value()));

        // Directed: sample extremes at frame start, extreme coefficients,
        // loads to missing taps, and loads whose frame start bit is random.
        word_backlog.push_back(sample_word(1'b1, 32'h7FFF_FFFF));
        word_backlog.push_back(sample_word(1'b0, 32'h8000_0000));
        word_backlog.push_back(load_word(6'd1, 32'h7FFF_FFFF));
        word_backlog.push_back(sample_word(1'b0, 32'h8000_0000));
        word_backlog.push_back(sample_word(1'b0, 32'h7FFF_FFFF));
        word_backlog.push_back(load_word(6'd1, 32'h8000_0000));
        word_backlog.push_back(sample_word(1'b0, 32'h8000_0000));
        word_backlog.push_back(sample_word(1'b0, 32'h0000_0000));
        word_backlog.push_back(sample_word(1'b0, 32'hFFFF_FFFF));
        word_backlog.push_back(load_word(6'd0, 32'h1234_5678));
        word_backlog.push_back(load_word(6'd33, 32'h8765_4321));
        word_backlog.push_back(load_word(6'd63, 32'hFFFF_FFFF));
        word_backlog.push_back(sample_word(1'b0, 32'h0000_0001));
        word_backlog.push_back(load_word(6'd1, 32'h0010_0000));
        word_backlog.push_back(sample_word(1'b0, 32'd12345));
        word_backlog.push_back(sample_word(1'b1, -32'sd7));
        word_backlog.push_back(sample_word(1'b0, 32'd100));
        word_backlog.push_back(load_word(6'd32, 32'h7FFF_FFFF));
        settle();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_ORDER, DATA_W'(order_plan[p]));
            write_reg(REG_SHIFT, DATA_W'(shift_plan[p]));
            settings_run++;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            word_backlog.push_back(sample_word(1'b1, pick_value()));
            for (n = 1; n < PHASE_WORDS; n++)
                word_backlog.push_back(make_word());
            if (p == 4)
                hold_go = 1'b1;
            settle();
        end

        if (residue_due.size() != 0) begin
            mismatches++;
            $display("%0d residues never arrived", residue_due.size());
        end
        $display("Covered %0d samples in %0d frames and %0d coefficient loads",
                 samples_run, frames_run, loads_run);
        $display("over %0d order/shift settings; %0d residues checked, %0d mismatches",
                 settings_run, residues_seen, mismatches);
        if (mismatches == 0)
            $display("lpc_residue_filter_top regression: pass");
        else
            $display("lpc_residue_filter_top regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lrf_pkg.sv
sv/lrf_ifs.sv
sv/lrf_ctrl.sv
sv/lrf_datapath.sv
sv/lpc_residue_filter_top.sv
verif/lpc_residue_filter_top_test.sv
